// ===== rtl/tnrc_pkg.sv =====
// Shared types and constants of the tree network route compute unit.
package tnrc_pkg;

   localparam int ID_WIDTH    = 27;
   localparam int MAX_DIGITS  = 8;
   localparam int BCD_DIGITS  = 9;
   localparam int DIGIT_W     = 4;
   localparam int BCD_W       = BCD_DIGITS * DIGIT_W;
   localparam int LEN_W       = $clog2(MAX_DIGITS + 1);
   localparam int DD_STEPS    = 7;
   localparam int DD_STAGES   = (ID_WIDTH + DD_STEPS - 1) / DD_STEPS;
   localparam int RSP_LATENCY = DD_STAGES + 2;

   typedef logic [ID_WIDTH-1:0]                 id_type;
   typedef logic [BCD_W-1:0]                    bcd_type;
   typedef logic [DIGIT_W-1:0]                  digit_type;
   typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0]  dec_id_type;
   typedef logic [LEN_W-1:0]                    len_type;

   typedef enum logic [2:0] {
      PORT_LOCAL = 3'd0,
      PORT_NORTH = 3'd1,
      PORT_SOUTH = 3'd2,
      PORT_EAST  = 3'd3,
      PORT_WEST  = 3'd4,
      PORT_NONE  = 3'd5
   } port_type;

endpackage

// ===== rtl/tnrc_bcd_pipe.sv =====
// Pipelined binary to BCD converter (shift and add-3), a few bits per stage.
module tnrc_bcd_pipe (
   input  logic             clock,
   input  tnrc_pkg::id_type  bin_value,
   output tnrc_pkg::bcd_type bcd_value
);
   import tnrc_pkg::*;

   function automatic bcd_type dd_step(input bcd_type b, input logic bit_in);
      bcd_type   r;
      digit_type d;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         d = b[i*DIGIT_W +: DIGIT_W];
         if (d >= DIGIT_W'(5)) begin
            d = d + DIGIT_W'(3);
         end
         r[i*DIGIT_W +: DIGIT_W] = d;
      end
      return {r[BCD_W-2:0], bit_in};
   endfunction

   bcd_type stage_bcd_ff  [DD_STAGES];
   bcd_type stage_bcd_in  [DD_STAGES];
   bcd_type stage_bcd_src [DD_STAGES];
   id_type  stage_bin_src [DD_STAGES];
   id_type  stage_bin_ff  [DD_STAGES-1];

   assign stage_bcd_src[0] = '0;
   assign stage_bin_src[0] = bin_value;

   for (genvar g = 1; g < DD_STAGES; g++) begin : g_link
      assign stage_bcd_src[g] = stage_bcd_ff[g-1];
      assign stage_bin_src[g] = stage_bin_ff[g-1];
   end

   for (genvar g = 0; g < DD_STAGES; g++) begin : g_stage
      always_comb begin
         bcd_type b;
         id_type  v;
         b = stage_bcd_src[g];
         v = stage_bin_src[g];
         for (int t = 0; t < DD_STEPS; t++) begin
            if (g * DD_STEPS + t < ID_WIDTH) begin
               b = dd_step(b, v[ID_WIDTH-1]);
               v = {v[ID_WIDTH-2:0], 1'b0};
            end
         end
         stage_bcd_in[g] = b;
      end

      always_ff @(posedge clock) begin
         stage_bcd_ff[g] <= stage_bcd_in[g];
      end

      if (g < DD_STAGES - 1) begin : g_bin
         always_ff @(posedge clock) begin
            stage_bin_ff[g] <= stage_bin_src[g] << DD_STEPS;
         end
      end
   end

   assign bcd_value = stage_bcd_ff[DD_STAGES-1];

endmodule

// ===== rtl/tree_noc_route_compute_unit.sv =====
// Top level of the tree network route compute unit.
//
// Route compute for a tree-shaped network: each packet word carries source and
// destination node ids, written as decimal numbers whose leading digits 1 to 4
// name the direction of a child from its parent. A word is taken at every rising
// edge with start high and busy low; busy is high only while reset is held, so a
// new word may follow in every cycle. The result appears on rsp_out_port for one
// cycle with rsp_strobe high, one result per word, in order; the receiver cannot
// stall. Between a word and its result lie the input register, the four stages of
// the decimal converters (seven bits a stage, six in the last) and the decision
// register. Only the low eight decimal digits of every id count, own_node_id
// included. own_node_id is written through the csr_ port and must only change
// while no word is in flight.
module tree_noc_route_compute_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  tnrc_pkg::id_type   req_src_node,
   input  tnrc_pkg::id_type   req_dst_node,
   output logic               rsp_strobe,
   output tnrc_pkg::port_type rsp_out_port,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  tnrc_pkg::id_type   csr_own_node_id
);
   import tnrc_pkg::*;

   // Down move by a child digit of the destination.
   function automatic port_type port_down(input digit_type d);
      unique case (d)
         DIGIT_W'(1): return PORT_NORTH;
         DIGIT_W'(2): return PORT_SOUTH;
         DIGIT_W'(3): return PORT_WEST;
         DIGIT_W'(4): return PORT_EAST;
         default:     return PORT_NONE;
      endcase
   endfunction

   // Up move by this node's own leading digit.
   function automatic port_type port_up(input digit_type d);
      unique case (d)
         DIGIT_W'(1): return PORT_SOUTH;
         DIGIT_W'(2): return PORT_NORTH;
         DIGIT_W'(3): return PORT_EAST;
         DIGIT_W'(4): return PORT_WEST;
         default:     return PORT_NONE;
      endcase
   endfunction

   logic accept;

   id_type   own_ff;
   id_type   src_ff, dst_ff, cur_ff;
   logic     req_vld_ff;
   logic [DD_STAGES-1:0] conv_vld_ff;
   logic     rsp_vld_ff;
   port_type rsp_port_ff;
   port_type rsp_port_in;

   bcd_type    src_bcd, dst_bcd, cur_bcd;
   dec_id_type sdig, ddig, cdig;

   // Hold off words only while reset is applied; the pipeline never stalls.
   assign busy      = reset;
   assign accept    = start & ~busy;
   assign csr_ready = ~reset;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         own_ff <= csr_own_node_id;
      end
   end

   // Input register: capture ids and a copy of this node's id with each word.
   always_ff @(posedge clock) begin
      if (accept) begin
         src_ff <= req_src_node;
         dst_ff <= req_dst_node;
         cur_ff <= own_ff;
      end
   end

   // Valid bits follow the words through the converters.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff  <= 1'b0;
         conv_vld_ff <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         req_vld_ff  <= accept;
         conv_vld_ff <= {conv_vld_ff[DD_STAGES-2:0], req_vld_ff};
         rsp_vld_ff  <= conv_vld_ff[DD_STAGES-1];
      end
   end

   tnrc_bcd_pipe u_src_conv (.clock(clock), .bin_value(src_ff), .bcd_value(src_bcd));
   tnrc_bcd_pipe u_dst_conv (.clock(clock), .bin_value(dst_ff), .bcd_value(dst_bcd));
   tnrc_bcd_pipe u_cur_conv (.clock(clock), .bin_value(cur_ff), .bcd_value(cur_bcd));

   // Drop every digit above the low MAX_DIGITS.
   assign sdig = dec_id_type'(src_bcd[MAX_DIGITS*DIGIT_W-1:0]);
   assign ddig = dec_id_type'(dst_bcd[MAX_DIGITS*DIGIT_W-1:0]);
   assign cdig = dec_id_type'(cur_bcd[MAX_DIGITS*DIGIT_W-1:0]);

   // Route decision, all digit positions compared side by side.
   always_comb begin
      len_type   slen, dlen, clen, mlen, klen;
      logic      run;
      logic      cur_is_dst, cur_is_shared;
      logic [MAX_DIGITS-1:0] e_flag;
      logic [MAX_DIGITS:0]   f_flag;
      digit_type c_lead, dl, dk;
      port_type  down_port, walk_port;
      logic      decided, go_up;

      slen   = '0;
      dlen   = '0;
      clen   = '0;
      mlen   = '0;
      c_lead = '0;
      run    = 1'b1;
      for (int j = 0; j < MAX_DIGITS; j++) begin
         if (sdig[j] != '0) slen = len_type'(j + 1);
         if (ddig[j] != '0) dlen = len_type'(j + 1);
         if (cdig[j] != '0) begin
            clen   = len_type'(j + 1);
            c_lead = cdig[j];
         end
         run = run & (sdig[j] == ddig[j]);
         if (run) mlen = len_type'(j + 1);
      end

      // Shared ancestor: the common low digits, no longer than the source id.
      klen = (slen < mlen) ? slen : mlen;

      cur_is_dst    = (cdig == ddig);
      cur_is_shared = 1'b1;
      for (int j = 0; j < MAX_DIGITS; j++) begin
         if (cdig[j] != ((len_type'(j) < klen) ? sdig[j] : '0)) cur_is_shared = 1'b0;
      end

      // e_flag[m]: destination with its digits from m up dropped equals this node.
      for (int m = 0; m < MAX_DIGITS; m++) begin
         e_flag[m] = 1'b1;
         for (int j = 0; j < MAX_DIGITS; j++) begin
            if (cdig[j] != ((j < m) ? ddig[j] : '0)) e_flag[m] = 1'b0;
         end
      end

      // f_flag[l]: destination cut to l digits equals the shared ancestor.
      for (int l = 0; l <= MAX_DIGITS; l++) begin
         f_flag[l] = 1'b1;
         for (int j = 0; j < MAX_DIGITS; j++) begin
            dl = (j < l) ? ddig[j] : '0;
            dk = (len_type'(j) < klen) ? ddig[j] : '0;
            if (dl != dk) f_flag[l] = 1'b0;
         end
      end

      // At the ancestor: longest destination prefix whose parent is this node.
      down_port = PORT_NONE;
      for (int m = 0; m < MAX_DIGITS; m++) begin
         if (len_type'(m) < dlen && e_flag[m]) down_port = port_down(ddig[m]);
      end

      // Elsewhere: walk the destination up toward the ancestor.
      decided   = 1'b0;
      go_up     = 1'b0;
      walk_port = PORT_NONE;
      for (int l = MAX_DIGITS; l >= 1; l--) begin
         if (!decided && len_type'(l) <= dlen) begin
            if (f_flag[l]) begin
               decided = 1'b1;
               go_up   = 1'b1;
            end else if (e_flag[l-1]) begin
               decided   = 1'b1;
               walk_port = port_down(ddig[l-1]);
            end
         end
      end
      // Out of digits: go up if the empty suffix is the ancestor, else drop to none.
      if (!decided) begin
         if (f_flag[0]) begin
            go_up = 1'b1;
         end else begin
            walk_port = PORT_NONE;
         end
      end

      if (cur_is_dst) begin
         rsp_port_in = PORT_LOCAL;
      end else if (cur_is_shared) begin
         rsp_port_in = down_port;
      end else if (go_up) begin
         rsp_port_in = (clen == '0) ? PORT_NONE : port_up(c_lead);
      end else begin
         rsp_port_in = walk_port;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      rsp_port_ff <= rsp_port_in;
   end

   assign rsp_strobe   = rsp_vld_ff;
   assign rsp_out_port = rsp_port_ff;

endmodule

// ===== rtl/tnrc_checker.sv =====
// Port-level checker of the route compute unit and its bind.
module tnrc_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input tnrc_pkg::id_type   req_dst_node,
   input logic               rsp_strobe,
   input tnrc_pkg::port_type rsp_out_port,
   input logic               csr_valid,
   input logic               csr_ready,
   input tnrc_pkg::id_type   csr_own_node_id
);
   import tnrc_pkg::*;

   id_type own_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_seen_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         own_seen_ff <= csr_own_node_id;
      end
   end

   a_word_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##RSP_LATENCY rsp_strobe)
      else $error("accepted word produced no result");

   a_result_has_word: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, RSP_LATENCY))
      else $error("result without an accepted word");

   a_local_delivery: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_dst_node == own_seen_ff)
         |-> ##RSP_LATENCY (rsp_out_port == PORT_LOCAL))
      else $error("packet for this node not delivered locally");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe after reset");

endmodule

bind tree_noc_route_compute_unit tnrc_checker u_tnrc_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_dst_node    (req_dst_node),
   .rsp_strobe      (rsp_strobe),
   .rsp_out_port    (rsp_out_port),
   .csr_valid       (csr_valid),
   .csr_ready       (csr_ready),
   .csr_own_node_id (csr_own_node_id)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for the tree network route compute unit.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tnrc_pkg::*;

   localparam int     CLOCK_PERIOD = 20;
   localparam int     RESET_CYCLES = 8;
   localparam int     PHASE_COUNT  = 14;
   localparam int     PHASE_WORDS  = 100;
   localparam int     REPORT_LIMIT = 10;
   localparam int     CYCLE_LIMIT  = 200000;
   localparam int     DIRECTED_ROWS = 24;
   localparam id_type ID_ALL_ONES  = '1;

   // One directed word: router id to load, the packet ids, and the port when it
   // is obvious enough to type in by hand (known set), else the predictor decides.
   typedef struct packed {
      id_type   own;
      id_type   src;
      id_type   dst;
      logic     known;
      port_type port;
   } directed_row_type;

   // One route decision still owed by the block, with its inputs for reporting.
   typedef struct {
      id_type   src;
      id_type   dst;
      id_type   own;
      port_type port;
   } route_expect_type;

   logic     clock;
   logic     reset;
   logic     start;
   logic     busy;
   id_type   req_src_node;
   id_type   req_dst_node;
   logic     rsp_strobe;
   port_type rsp_out_port;
   logic     csr_valid;
   logic     csr_ready;
   id_type   csr_own_node_id;

   route_expect_type pending_routes[$];
   directed_row_type directed_rows [DIRECTED_ROWS];
   id_type           own_shadow;
   int               idle_pct;
   int unsigned      mismatch_count;
   int unsigned      cycle_count;

   tree_noc_route_compute_unit uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_src_node    (req_src_node),
      .req_dst_node    (req_dst_node),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_port    (rsp_out_port),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_own_node_id (csr_own_node_id)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Route predictor, decimal arithmetic on 64-bit values.
   // ---------------------------------------------------------------------
   function automatic longint unsigned pow10(int n);
      longint unsigned p;
      p = 1;
      for (int i = 0; i < n; i++) p = p * 10;
      return p;
   endfunction

   // Keep only the low MAX_DIGITS decimal digits of an id.
   function automatic longint unsigned trim_id(id_type v);
      return 64'(v) % pow10(MAX_DIGITS);
   endfunction

   function automatic int dec_len(longint unsigned v);
      int n;
      n = 0;
      for (int k = 1; k <= MAX_DIGITS; k++)
         if (v >= pow10(k - 1)) n = k;
      return n;
   endfunction

   // Steer down toward a child named by its leading digit.
   function automatic port_type down_port(longint unsigned digit);
      case (digit)
         1: return PORT_NORTH;
         2: return PORT_SOUTH;
         3: return PORT_WEST;
         4: return PORT_EAST;
         default: return PORT_NONE;
      endcase
   endfunction

   // Steer up, toward the parent, by this node's own leading digit.
   function automatic port_type up_port(longint unsigned digit);
      case (digit)
         1: return PORT_SOUTH;
         2: return PORT_NORTH;
         3: return PORT_EAST;
         4: return PORT_WEST;
         default: return PORT_NONE;
      endcase
   endfunction

   function automatic port_type route_of(id_type src, id_type dst, id_type own);
      longint unsigned s, d, c, anc, t;
      int              n, cl;
      bit              matching, done;
      port_type        port;
      s     = trim_id(src);
      d     = trim_id(dst);
      c     = trim_id(own);
      anc   = 0;
      port  = PORT_NONE;
      // Shared ancestor: longest common decimal suffix over the source digits.
      matching = 1'b1;
      for (int k = 1; k <= MAX_DIGITS; k++) begin
         if (matching && s % pow10(k) == d % pow10(k) && s / pow10(k - 1) != 0)
            anc = s % pow10(k);
         else
            matching = 1'b0;
      end
      if (c == d) begin
         port = PORT_LOCAL;
      end else if (c == anc) begin
         // At the ancestor: find the destination suffix that hangs below us.
         n = dec_len(d);
         while (n > 0 && d % pow10(n - 1) != c) n--;
         if (n > 0) port = down_port((d % pow10(n)) / pow10(n - 1));
      end else begin
         // Walk the destination suffixes down to the ancestor; steer down if
         // one of them is our child, else go up.
         t    = d;
         n    = dec_len(d);
         done = 1'b0;
         while (!done && t != anc) begin
            if (n == 0) begin
               done = 1'b1;
               port = PORT_NONE;
            end else if (t % pow10(n - 1) == c) begin
               done = 1'b1;
               port = down_port(t / pow10(n - 1));
            end else begin
               t = t % pow10(n - 1);
               n--;
            end
         end
         if (!done) begin
            cl   = dec_len(c);
            port = (cl == 0) ? PORT_NONE : up_port(c / pow10(cl - 1));
         end
      end
      return port;
   endfunction

   // Prepend a random number of child digits above the low blen digits of base.
   // Mostly tree digits 1 to 4, now and then a stray one to reach the none ports.
   function automatic id_type grow_id(longint unsigned base, int blen);
      longint unsigned v, digit;
      int              extra, pick;
      v     = base;
      extra = (blen >= MAX_DIGITS) ? 0 : $urandom_range(MAX_DIGITS - blen, 0);
      for (int i = 0; i < extra; i++) begin
         if ($urandom_range(99) < 94) begin
            digit = $urandom_range(4, 1);
         end else begin
            pick  = $urandom_range(5);
            digit = (pick == 0) ? 0 : pick + 4;
         end
         v = v + digit * pow10(blen + i);
      end
      return id_type'(v);
   endfunction

   // ---------------------------------------------------------------------
   // Drivers.
   // ---------------------------------------------------------------------

   // Offer one packet word, idling first at the phase's rate, and hold it until
   // the block takes it. Leave start high so a back-to-back word needs no toggle.
   task automatic send_route(id_type src, id_type dst, port_type want);
      route_expect_type entry;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start        <= 1'b1;
      req_src_node <= src;
      req_dst_node <= dst;
      @(posedge clock);
      while (busy) @(posedge clock);
      entry = '{src, dst, own_shadow, want};
      pending_routes.push_back(entry);
   endtask

   // Drain every outstanding decision, let the pipe settle, then load a new
   // router id through the csr channel.
   task automatic set_own(id_type value);
      start <= 1'b0;
      while (pending_routes.size() != 0) @(posedge clock);
      repeat (RSP_LATENCY) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_own_node_id <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      own_shadow = value;
   endtask

   // ---------------------------------------------------------------------
   // Result checker: every strobe must match the oldest owed decision.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      route_expect_type want;
      if (!reset && rsp_strobe) begin
         if (pending_routes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("ROUTE ERROR at %0t: unexpected word, port %0d",
                        $realtime, rsp_out_port);
         end else begin
            want = pending_routes.pop_front();
            if (rsp_out_port !== want.port) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("ROUTE ERROR at %0t: own %0d src %0d dst %0d: expected %0d got %0d",
                           $realtime, want.own, want.src, want.dst, want.port,
                           rsp_out_port);
            end
         end
      end
   end

   // Watchdog: end the run if the block stops answering.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus.
   // ---------------------------------------------------------------------
   initial begin
      longint unsigned cur;
      int              clen, j, pick;
      id_type          src, dst, own;

      mismatch_count  = 0;
      cycle_count     = 0;
      own_shadow      = '0;
      idle_pct        = 0;
      reset           <= 1'b1;
      start           <= 1'b0;
      req_src_node    <= '0;
      req_dst_node    <= '0;
      csr_valid       <= 1'b0;
      csr_own_node_id <= '0;

      // Hand-picked words: id extremes, ids too long for the digit budget,
      // source zero, up moves from node zero, and a mix of down and up moves.
      directed_rows = '{
         '{27'd0,         27'd0,         27'd0,         1'b1, PORT_LOCAL},
         '{27'd0,         27'd0,         27'd3,         1'b1, PORT_WEST},
         '{27'd0,         ID_ALL_ONES,   ID_ALL_ONES,   1'b1, PORT_NONE},
         '{27'd0,         27'd12,        27'd34,        1'b0, PORT_NONE},
         '{27'd0,         27'd0,         27'd99999999,  1'b1, PORT_NONE},
         '{27'd99999999,  27'd0,         27'd99999999,  1'b1, PORT_LOCAL},
         '{27'd99999999,  27'd1,         27'd2,         1'b1, PORT_NONE},
         '{ID_ALL_ONES,   27'd0,         27'd34217727,  1'b1, PORT_LOCAL},
         '{ID_ALL_ONES,   27'd1,         27'd1,         1'b0, PORT_NONE},
         '{ID_ALL_ONES,   ID_ALL_ONES,   27'd0,         1'b0, PORT_NONE},
         '{27'd100000001, 27'd2,         27'd1,         1'b1, PORT_LOCAL},
         '{27'd100000001, 27'd21,        27'd31,        1'b0, PORT_NONE},
         '{27'd100000001, 27'd123456789, 27'd41,        1'b0, PORT_NONE},
         '{27'd100000001, 27'd2,         27'd2,         1'b0, PORT_NONE},
         '{27'd21,        27'd321,       27'd421,       1'b0, PORT_NONE},
         '{27'd21,        27'd121,       27'd3,         1'b0, PORT_NONE},
         '{27'd21,        27'd3,         27'd21,        1'b1, PORT_LOCAL},
         '{27'd21,        27'd4121,      27'd2121,      1'b0, PORT_NONE},
         '{27'd21,        27'd1,         27'd1,         1'b0, PORT_NONE},
         '{27'd44444444,  27'd44444444,  27'd44444444,  1'b1, PORT_LOCAL},
         '{27'd44444444,  27'd14444444,  27'd24444444,  1'b0, PORT_NONE},
         '{27'd44444444,  27'd5,         27'd6,         1'b0, PORT_NONE},
         '{27'd0,         27'd5,         27'd5,         1'b1, PORT_NONE},
         '{27'd0,         27'd100000000, 27'd5,         1'b0, PORT_NONE}
      };

      // Hold reset, then release it once.
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the table; reload the router id only where a row asks for another.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].own != own_shadow) set_own(directed_rows[i].own);
         send_route(directed_rows[i].src, directed_rows[i].dst,
                    directed_rows[i].known ? directed_rows[i].port :
                    route_of(directed_rows[i].src, directed_rows[i].dst, own_shadow));
      end

      // Random phases: each loads a router id (drained first, so the sender
      // waits for every owed word) and runs at its own idle rate.
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph % 7)
            1:       own = id_type'($urandom);
            2:       own = '0;
            3:       own = 27'd99999999;
            4:       own = ID_ALL_ONES;
            default: own = grow_id(0, 0);
         endcase
         set_own(own);
         case (ph % 4)
            1:       idle_pct = 84;
            3:       idle_pct = 21;
            default: idle_pct = 0;
         endcase
         cur  = trim_id(own_shadow);
         clen = dec_len(cur);

         for (int w = 0; w < PHASE_WORDS; w++) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
               // Raw noise over the full field width.
               src = id_type'($urandom);
               dst = id_type'($urandom);
            end else begin
               // Ids on the tree around this router: grow each from a random
               // suffix of our own id so ancestors, children and siblings show up.
               j   = $urandom_range(clen, 0);
               src = grow_id(cur % pow10(j), j);
               j   = $urandom_range(clen, 0);
               dst = grow_id(cur % pow10(j), j);
               if (pick < 17)
                  dst = id_type'(cur);
               else if (pick < 25)
                  src = dst;
            end
            send_route(src, dst, route_of(src, dst, own_shadow));
         end
      end

      // Drop start, wait for every owed word, then give stragglers a window.
      start <= 1'b0;
      while (pending_routes.size() != 0) @(posedge clock);
      repeat (RSP_LATENCY + 4) @(posedge clock);

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/tnrc_pkg.sv
rtl/tnrc_bcd_pipe.sv
rtl/tree_noc_route_compute_unit.sv
rtl/tnrc_checker.sv
sim/testbench.sv
